// ----- design/nco_oscillator_mixer_macros.svh -----
// assertion helpers for the oscillator/mixer block
// each use expects clk and rst_n in scope
`ifndef NCO_OSCILLATOR_MIXER_MACROS_SVH
`define NCO_OSCILLATOR_MIXER_MACROS_SVH

// same-cycle implication
`define NCO_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NCO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/nco_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package nco_pkg;

    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int PHASE_BITS_DEF      = 32;
    localparam int TABLE_ADDR_BITS_DEF = 10;

    // configuration register file
    localparam int REG_BITS  = 32;
    localparam int ADDR_BITS = 4;
    localparam int WAVE_BITS = 2;

    typedef enum logic [1:0] {
        REG_WAVE_MODE       = 2'd0,
        REG_MULTIPLY_ENABLE = 2'd1,
        REG_PHASE_STEP      = 2'd2,
        REG_START_PHASE     = 2'd3
    } reg_index_t;

    // the spare code runs as real cosine
    typedef enum logic [WAVE_BITS-1:0] {
        WAVE_COS  = 2'd0,
        WAVE_CPLX = 2'd1,
        WAVE_SAW  = 2'd2
    } wave_mode_t;

    typedef struct packed {
        logic [WAVE_BITS-1:0] wave_mode;
        logic                 multiply_enable;
        logic [REG_BITS-1:0]  phase_step;
        logic [REG_BITS-1:0]  start_phase;
    } cfg_t;

    typedef struct packed {
        logic                load;
        logic [REG_BITS-1:0] value;
    } phase_load_t;

    // odd polynomial for sin(pi/2*u), Q2.30 coefficients
    localparam logic [63:0] SIN_COEF [6] = '{
        64'd1686629713, 64'd693598668, 64'd85569306,
        64'd5026995, 64'd172272, 64'd3864
    };

    // quarter-wave magnitude at table position r, rounded to Q1.frac_bits
    // evaluated at elaboration only, to fill the sine table
    function automatic logic [63:0] quarter_mag(input int unsigned r,
                                                input int unsigned tab_bits,
                                                input int unsigned frac_bits);
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] s;
        logic [63:0] a;
        logic [63:0] lim;
        u  = 64'(r) << (30 - (tab_bits - 2));
        u2 = (u * u) >> 30;
        s  = SIN_COEF[5];
        for (int k = 4; k >= 0; k--)
        begin
            s = SIN_COEF[k] - ((s * u2) >> 30);
        end
        s   = (s * u) >> 30;
        a   = (s + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
        lim = (64'd1 << frac_bits) - 64'd1;
        return (a > lim) ? lim : a;
    endfunction

endpackage

`default_nettype wire

// ----- design/nco_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface nco_sample_if
    import nco_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_real;
    logic signed [SAMPLE_BITS-1:0] in_imag;
    logic                          block_end;

    modport source (output valid, in_real, in_imag, block_end, input ready);
    modport sink   (input valid, in_real, in_imag, block_end, output ready);
endinterface

interface nco_result_if
    import nco_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_real;
    logic signed [SAMPLE_BITS-1:0] out_imag;
    logic                          out_block_end;

    modport source (output valid, out_real, out_imag, out_block_end, input ready);
    modport sink   (input valid, out_real, out_imag, out_block_end, output ready);
endinterface

`default_nettype wire

// ----- design/nco_oscillator_mixer.sv -----
// Numerically controlled oscillator with optional real or complex mixer.
// Every sample beat on the input advances a wrapping phase accumulator by
// phase_step and yields one result beat: the real cosine, the cosine/sine
// pair, or a sawtooth of the phase fraction, or with multiply_enable set
// the input sample times that waveform, rounded half up and saturated to
// Q1.15 (complex product for the cosine/sine pair). Wave mode 3 runs as
// real cosine. Writing start_phase reloads the accumulator at once; write
// registers only while no beat is in flight. Throughput is one beat per
// clock while result ready is not held low; each beat passes through the
// input register and the output register, with the sine table read, the
// products, rounding and saturation in the logic between them. The sine
// table is a constant quarter-wave ROM of 2^(TABLE_ADDR_BITS-2)+1 entries
// read at two addresses per beat for cosine and sine. input ready follows
// output ready through the register valid chain, so a bubble anywhere in
// the pipe keeps the input open.
`timescale 1ns / 1ps
`default_nettype none

`include "nco_oscillator_mixer_macros.svh"

module nco_oscillator_mixer
    import nco_pkg::*;
#(
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration port, always ready
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [REG_BITS-1:0]  pwdata,
    output logic      [REG_BITS-1:0]  prdata,
    output logic                      pready,
    // sample stream in, result stream out
    nco_sample_if.sink                sample,
    nco_result_if.source              result
);

    cfg_t                  cfg;
    phase_load_t           pload;
    logic                  accept;
    logic [PHASE_BITS-1:0] phase;

    // register file, also raises the reload strobe for start_phase
    nco_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .pload   (pload)
    );

    // phase steps once per accepted sample beat
    nco_phase_acc #(
        .PHASE_BITS (PHASE_BITS)
    ) u_phase (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .pload   (pload),
        .advance (accept),
        .phase   (phase)
    );

    // input register, waveform and mixer logic, output register
    nco_datapath #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .phase  (phase),
        .accept (accept),
        .sample (sample),
        .result (result)
    );

    // an empty output stage must never block the input
    `NCO_ASSERT_IMP(a_ready_when_empty, !result.valid, sample.ready, "input blocked with empty output")

    // imaginary output is zero outside the complex mode
    `NCO_ASSERT_IMP(a_imag_zero, result.valid && (cfg.wave_mode != WAVE_CPLX), result.out_imag == '0, "nonzero imaginary output in a real mode")

    // plain sawtooth is a nonnegative fraction
    `NCO_ASSERT_IMP(a_saw_positive, result.valid && (cfg.wave_mode == WAVE_SAW) && !cfg.multiply_enable, !result.out_real[SAMPLE_BITS-1], "negative sawtooth")

    // a zero step leaves the phase alone
    `NCO_ASSERT_NEXT(a_phase_hold, accept && !pload.load && (cfg.phase_step == '0), $stable(phase), "phase moved with zero step")

endmodule

`default_nettype wire

// ----- design/nco_apb_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nco_apb_regs
    import nco_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [REG_BITS-1:0]  pwdata,
    output logic      [REG_BITS-1:0]  prdata,
    output logic                      pready,
    output cfg_t                      cfg,
    output phase_load_t               pload
);

    logic [WAVE_BITS-1:0] wave_mode_reg, wave_mode_next;
    logic                 multiply_enable_reg, multiply_enable_next;
    logic [REG_BITS-1:0]  phase_step_reg, phase_step_next;
    logic [REG_BITS-1:0]  start_phase_reg, start_phase_next;

    logic       wr;
    reg_index_t idx;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    // word addressed, byte lanes ignored
    assign idx    = reg_index_t'(paddr[ADDR_BITS-1:2]);

    always_comb
    begin
        wave_mode_next       = wave_mode_reg;
        multiply_enable_next = multiply_enable_reg;
        phase_step_next      = phase_step_reg;
        start_phase_next     = start_phase_reg;
        if (wr)
        begin
            unique case (idx)
                REG_WAVE_MODE:       wave_mode_next       = pwdata[WAVE_BITS-1:0];
                REG_MULTIPLY_ENABLE: multiply_enable_next = pwdata[0];
                REG_PHASE_STEP:      phase_step_next      = pwdata;
                REG_START_PHASE:     start_phase_next     = pwdata;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_mode_reg       <= '0;
            multiply_enable_reg <= 1'b0;
            phase_step_reg      <= '0;
            start_phase_reg     <= '0;
        end
        else
        begin
            wave_mode_reg       <= wave_mode_next;
            multiply_enable_reg <= multiply_enable_next;
            phase_step_reg      <= phase_step_next;
            start_phase_reg     <= start_phase_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_WAVE_MODE:       prdata = REG_BITS'(wave_mode_reg);
            REG_MULTIPLY_ENABLE: prdata = REG_BITS'(multiply_enable_reg);
            REG_PHASE_STEP:      prdata = phase_step_reg;
            REG_START_PHASE:     prdata = start_phase_reg;
        endcase
    end

    assign cfg.wave_mode       = wave_mode_reg;
    assign cfg.multiply_enable = multiply_enable_reg;
    assign cfg.phase_step      = phase_step_reg;
    assign cfg.start_phase     = start_phase_reg;

    assign pload.load  = wr && (idx == REG_START_PHASE);
    assign pload.value = pwdata;

endmodule

`default_nettype wire

// ----- design/nco_phase_acc.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nco_phase_acc
    import nco_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cfg_t                  cfg,
    input  wire phase_load_t           pload,
    input  wire logic                  advance,
    output logic      [PHASE_BITS-1:0] phase
);

    logic [PHASE_BITS-1:0] phase_reg, phase_next;

    // Q0.32 register to accumulator width, low bits dropped or zeros appended
    function automatic logic [PHASE_BITS-1:0] align(input logic [REG_BITS-1:0] v);
        logic [REG_BITS+15:0] w;
        w = {v, 16'b0};
        return w[REG_BITS+15 -: PHASE_BITS];
    endfunction

    always_comb
    begin
        priority if (pload.load)
            phase_next = align(pload.value);
        else if (advance)
            phase_next = phase_reg + align(cfg.phase_step);
        else
            phase_next = phase_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else
            phase_reg <= phase_next;
    end

    assign phase = phase_reg;

endmodule

`default_nettype wire

// ----- design/nco_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nco_datapath
    import nco_pkg::*;
#(
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cfg_t                  cfg,
    input  wire logic [PHASE_BITS-1:0] phase,
    output logic                       accept,
    nco_sample_if.sink                 sample,
    nco_result_if.source               result
);

    localparam int FRAC_BITS = SAMPLE_BITS - 1;
    localparam int QBITS     = TABLE_ADDR_BITS - 2;
    localparam int QUARTER   = 1 << QBITS;
    localparam int ROM_DEPTH = QUARTER + 1;
    localparam int ROM_ABITS = QBITS + 1;
    localparam int PW        = 2 * SAMPLE_BITS;
    localparam int SW        = PW + 1;
    localparam int RW        = SW - FRAC_BITS;

    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {FRAC_BITS{1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [SW-1:0]          HALF = SW'(1 << (FRAC_BITS - 1));

    typedef logic [SAMPLE_BITS-1:0] rom_t [ROM_DEPTH];

    function automatic rom_t build_rom();
        rom_t t;
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            t[i] = SAMPLE_BITS'(quarter_mag(i, TABLE_ADDR_BITS, FRAC_BITS));
        end
        return t;
    endfunction

    // quarter-wave magnitudes, both ends included
    localparam rom_t SINE_ROM = build_rom();

    // mirror odd quadrants onto the table
    function automatic logic [ROM_ABITS-1:0] fold_addr(
        input logic [TABLE_ADDR_BITS-1:0] idx);
        logic [ROM_ABITS-1:0] r;
        r = {1'b0, idx[QBITS-1:0]};
        return idx[QBITS] ? (ROM_ABITS'(QUARTER) - r) : r;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_q(input logic signed [RW-1:0] v);
        if (v[RW-1:FRAC_BITS] == {(RW - FRAC_BITS){v[RW-1]}})
            return v[SAMPLE_BITS-1:0];
        return v[RW-1] ? SMIN : SMAX;
    endfunction

    logic cplx, saw_mode;
    assign cplx     = (cfg.wave_mode == WAVE_CPLX);
    assign saw_mode = (cfg.wave_mode == WAVE_SAW);

    // handshake: a register loads when its successor is empty or moving
    logic v1_reg, v2_reg;
    logic adv1, adv2;

    assign adv2         = !v2_reg || result.ready;
    assign adv1         = !v1_reg || adv2;
    assign sample.ready = adv1;
    assign accept       = sample.valid && adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= sample.valid;
            if (adv2) v2_reg <= v1_reg;
        end
    end

    // input register: sample and phase
    logic signed [SAMPLE_BITS-1:0] xr1_reg, xi1_reg;
    logic                          be1_reg;
    logic [PHASE_BITS-1:0]         ph1_reg;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            xr1_reg <= sample.in_real;
            xi1_reg <= sample.in_imag;
            be1_reg <= sample.block_end;
            ph1_reg <= phase;
        end
    end

    // table read and waveform
    logic [TABLE_ADDR_BITS-1:0] sin_idx, cos_idx;
    logic [ROM_ABITS-1:0]       sin_addr, cos_addr;
    logic [PHASE_BITS+15:0]     ph_ext;
    logic [FRAC_BITS-1:0]       saw_bits;
    logic [SAMPLE_BITS-1:0]     cmag, smag;

    assign sin_idx  = ph1_reg[PHASE_BITS-1 -: TABLE_ADDR_BITS];
    assign cos_idx  = sin_idx + TABLE_ADDR_BITS'(QUARTER);
    assign sin_addr = fold_addr(sin_idx);
    assign cos_addr = fold_addr(cos_idx);
    assign ph_ext   = {ph1_reg, 16'b0};
    assign saw_bits = ph_ext[PHASE_BITS+15 -: FRAC_BITS];
    assign cmag     = SINE_ROM[cos_addr];
    assign smag     = SINE_ROM[sin_addr];

    logic signed [SAMPLE_BITS-1:0] saw_w, cos_w, sin_w, wre;
    logic signed [PW-1:0]          pa, pb, pc, pd;

    assign saw_w = {1'b0, saw_bits};
    assign cos_w = cos_idx[TABLE_ADDR_BITS-1] ? -$signed(cmag) : $signed(cmag);
    assign sin_w = sin_idx[TABLE_ADDR_BITS-1] ? -$signed(smag) : $signed(smag);
    assign wre   = saw_mode ? saw_w : cos_w;
    assign pa    = xr1_reg * wre;
    assign pb    = xi1_reg * sin_w;
    assign pc    = xi1_reg * cos_w;
    assign pd    = xr1_reg * sin_w;

    // sum, round half up, saturate
    logic signed [SW-1:0]          re_sum, im_sum, re_rnd, im_rnd;
    logic signed [SAMPLE_BITS-1:0] re_out, im_out;

    always_comb
    begin
        re_sum = SW'(pa) - (cplx ? SW'(pb) : SW'(0));
        im_sum = SW'(pc) + SW'(pd);
        re_rnd = re_sum + HALF;
        im_rnd = im_sum + HALF;
        if (cfg.multiply_enable)
        begin
            re_out = sat_q(RW'(re_rnd >>> FRAC_BITS));
            im_out = cplx ? sat_q(RW'(im_rnd >>> FRAC_BITS)) : '0;
        end
        else
        begin
            re_out = wre;
            im_out = cplx ? sin_w : '0;
        end
    end

    // result register
    logic signed [SAMPLE_BITS-1:0] re2_reg, im2_reg;
    logic                          be2_reg;

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            re2_reg <= re_out;
            im2_reg <= im_out;
            be2_reg <= be1_reg;
        end
    end

    assign result.valid         = v2_reg;
    assign result.out_real      = re2_reg;
    assign result.out_imag      = im2_reg;
    assign result.out_block_end = be2_reg;

endmodule

`default_nettype wire
